// ===== hw/rtl/coc_pkg.sv =====
// Shared codes, types and the built-in arrow shape of the cursor overlay compositor.
package coc_pkg;

	localparam logic [2:0] ACT_PIXEL  = 3'd0;
	localparam logic [2:0] ACT_MOVE   = 3'd1;
	localparam logic [2:0] ACT_BEGIN  = 3'd2;
	localparam logic [2:0] ACT_ROW    = 3'd3;
	localparam logic [2:0] ACT_ARROW  = 3'd4;

	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CURSOR_ENABLE = 2'd2;
	localparam logic [1:0] REG_HOST_CURSOR   = 2'd3;

	localparam int unsigned ROW_BITS = 16;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1024;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd768;
	localparam logic [11:0] CURSOR_X_RST     = 12'd512;
	localparam logic [11:0] CURSOR_Y_RST     = 12'd384;

	localparam logic [31:0] PIXEL_BLACK = 32'h0000_0000;
	localparam logic [31:0] PIXEL_WHITE = 32'h00FF_FFFF;

	typedef logic [ROW_BITS-1:0] plane_row_t;

	function automatic plane_row_t arrow_outline(input logic [3:0] row);
		plane_row_t r;
		case (row)
			4'd0:    r = 16'hFFFF;
			4'd1:    r = 16'h8001;
			4'd2:    r = 16'h8002;
			4'd3:    r = 16'h800C;
			4'd4:    r = 16'h8010;
			4'd5:    r = 16'h8010;
			4'd6:    r = 16'h8008;
			4'd7:    r = 16'h8004;
			4'd8:    r = 16'h8002;
			4'd9:    r = 16'h8001;
			4'd10:   r = 16'h8002;
			4'd11:   r = 16'h8C04;
			4'd12:   r = 16'h9208;
			4'd13:   r = 16'h9110;
			4'd14:   r = 16'hA0A0;
			default: r = 16'hC040;
		endcase
		return r;
	endfunction

	function automatic plane_row_t arrow_body(input logic [3:0] row);
		plane_row_t r;
		case (row)
			4'd0:    r = 16'h0000;
			4'd1:    r = 16'h7FFE;
			4'd2:    r = 16'h7FFC;
			4'd3:    r = 16'h7FF0;
			4'd4:    r = 16'h7FE0;
			4'd5:    r = 16'h7FE0;
			4'd6:    r = 16'h7FF0;
			4'd7:    r = 16'h7FF8;
			4'd8:    r = 16'h7FFC;
			4'd9:    r = 16'h7FFE;
			4'd10:   r = 16'h7FFC;
			4'd11:   r = 16'h73F8;
			4'd12:   r = 16'h61F0;
			4'd13:   r = 16'h60E0;
			4'd14:   r = 16'h4040;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/cursor_overlay_compositor.sv =====
// Top level of the two-plane software cursor overlay compositor.
//
// Items enter on the input channel (in_valid, in_stall) and are registered in
// stage one. There a pixel is checked against the frame size and the cursor
// box and composited against the body and outline planes, while the other
// actions move the cursor, begin a shape, load a shape row or restore the
// arrow. Pixels inside the frame leave on the output channel (out_valid,
// out_stall) from the stage two register; all other items give no transaction.
// An accepted item waits in stage one and its result in the stage two register,
// and one item is taken every cycle while the output register is free to
// advance. When the receiver stalls a held result, stage one holds its item
// and in_stall rises while stage one is occupied. Reset empties both stages,
// restores the arrow shape, centers the cursor in the default frame and loads
// the register defaults. Configuration writes on cfg_write take effect at the
// next edge. The user must make them while the block is idle; the block itself
// does not enforce this.
module cursor_overlay_compositor
	import coc_pkg::*;
#(
	parameter int unsigned CURSOR_WIDTH  = 16,
	parameter int unsigned CURSOR_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [11:0]        pos_x,
	input  logic [11:0]        pos_y,
	input  logic [31:0]        pixel_in,
	input  logic signed [6:0]  hot_x_in,
	input  logic signed [6:0]  hot_y_in,
	input  logic [7:0]         source_bytes_per_row,
	input  logic [7:0]         source_rows,
	input  logic [3:0]         row_index,
	input  logic [15:0]        outline_bits,
	input  logic [15:0]        body_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        pixel_out,
	output logic               cursor_drawn
);

	localparam int unsigned PLANE_ROWS = (CURSOR_HEIGHT < ROW_BITS) ? CURSOR_HEIGHT : ROW_BITS;
	localparam int unsigned ROW_W      = $clog2(PLANE_ROWS);
	localparam int unsigned CW_W       = $clog2(CURSOR_WIDTH + 1);
	localparam int unsigned CH_W       = $clog2(CURSOR_HEIGHT + 1);
	localparam int unsigned MAX_BYTES  = CURSOR_WIDTH / 8;
	localparam logic [CW_W-1:0] WIDTH_RST  = CW_W'(CURSOR_WIDTH);
	localparam logic [CH_W-1:0] HEIGHT_RST = CH_W'(CURSOR_HEIGHT);

	logic [12:0]        frame_width_q;
	logic [12:0]        frame_height_q;
	logic               cursor_enable_q;
	logic               host_cursor_q;

	plane_row_t         outline_plane_q [PLANE_ROWS];
	plane_row_t         body_plane_q    [PLANE_ROWS];
	logic [CW_W-1:0]    cursor_width_q;
	logic [CH_W-1:0]    cursor_height_q;
	logic signed [6:0]  hot_x_q;
	logic signed [6:0]  hot_y_q;
	logic [11:0]        cursor_x_q;
	logic [11:0]        cursor_y_q;

	logic               valid_s1;
	logic [2:0]         action_s1;
	logic [11:0]        pos_x_s1;
	logic [11:0]        pos_y_s1;
	logic [31:0]        pixel_s1;
	logic signed [6:0]  hot_x_s1;
	logic signed [6:0]  hot_y_s1;
	logic [7:0]         bytes_s1;
	logic [7:0]         rows_s1;
	logic [3:0]         row_index_s1;
	logic [15:0]        outline_s1;
	logic [15:0]        body_s1;

	logic               valid_s2;
	logic [31:0]        pixel_s2;
	logic               drawn_s2;

	logic               advance;
	logic               fire_s1;
	logic               in_frame;
	logic               overlay_on;
	logic signed [14:0] box_x;
	logic signed [14:0] box_y;
	logic               in_box;
	logic [ROW_W-1:0]   box_row;
	logic [3:0]         box_bit;
	logic               body_hit;
	logic               outline_hit;
	logic [31:0]        pixel_res;
	logic               drawn_res;
	logic [CW_W-1:0]    new_width;
	logic [CH_W-1:0]    new_height;
	logic               row_ok;

	assign advance   = !valid_s2 || !out_stall;
	assign fire_s1   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;

	assign out_valid    = valid_s2;
	assign pixel_out    = pixel_s2;
	assign cursor_drawn = drawn_s2;

	always_comb begin
		in_frame   = ({1'b0, pos_x_s1} < frame_width_q) && ({1'b0, pos_y_s1} < frame_height_q);
		overlay_on = !host_cursor_q && cursor_enable_q && (cursor_width_q != '0);
		box_x = $signed({3'b000, pos_x_s1}) - $signed({3'b000, cursor_x_q})
			+ $signed({{8{hot_x_q[6]}}, hot_x_q});
		box_y = $signed({3'b000, pos_y_s1}) - $signed({3'b000, cursor_y_q})
			+ $signed({{8{hot_y_q[6]}}, hot_y_q});
		in_box = !box_x[14] && !box_y[14]
			&& (box_x[13:0] < 14'(cursor_width_q)) && (box_x[13:0] < 14'(ROW_BITS))
			&& (box_y[13:0] < 14'(cursor_height_q)) && (box_y[13:0] < 14'(PLANE_ROWS));
		box_row     = box_y[ROW_W-1:0];
		box_bit     = 4'd15 - box_x[3:0];
		body_hit    = body_plane_q[box_row][box_bit];
		outline_hit = outline_plane_q[box_row][box_bit];
		pixel_res   = pixel_s1;
		drawn_res   = 1'b0;
		if (overlay_on && in_box) begin
			if (body_hit) begin
				pixel_res = PIXEL_BLACK;
				drawn_res = 1'b1;
			end else if (outline_hit) begin
				pixel_res = PIXEL_WHITE;
				drawn_res = 1'b1;
			end
		end
	end

	always_comb begin
		if (bytes_s1 > 8'(MAX_BYTES)) begin
			new_width = CW_W'(MAX_BYTES * 8);
		end else begin
			new_width = CW_W'({bytes_s1, 3'b000});
		end
		if (rows_s1 > 8'(CURSOR_HEIGHT)) begin
			new_height = HEIGHT_RST;
		end else begin
			new_height = CH_W'(rows_s1);
		end
		row_ok = ({3'b000, row_index_s1} < 7'(cursor_height_q))
			&& ({1'b0, row_index_s1} < 5'(PLANE_ROWS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			cursor_enable_q <= 1'b0;
			host_cursor_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data;
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				REG_CURSOR_ENABLE: cursor_enable_q <= cfg_data[0];
				REG_HOST_CURSOR:   host_cursor_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_ROWS; i++) begin
				outline_plane_q[i] <= arrow_outline(4'(i));
				body_plane_q[i]    <= arrow_body(4'(i));
			end
			cursor_width_q  <= WIDTH_RST;
			cursor_height_q <= HEIGHT_RST;
			hot_x_q         <= '0;
			hot_y_q         <= '0;
			cursor_x_q      <= CURSOR_X_RST;
			cursor_y_q      <= CURSOR_Y_RST;
		end else if (fire_s1) begin
			case (action_s1)
				ACT_MOVE: begin
					if (!host_cursor_q) begin
						cursor_x_q <= pos_x_s1;
						cursor_y_q <= pos_y_s1;
					end
				end
				ACT_BEGIN: begin
					for (int i = 0; i < PLANE_ROWS; i++) begin
						outline_plane_q[i] <= '0;
						body_plane_q[i]    <= '0;
					end
					cursor_width_q  <= new_width;
					cursor_height_q <= new_height;
					hot_x_q         <= hot_x_s1;
					hot_y_q         <= hot_y_s1;
				end
				ACT_ROW: begin
					if (row_ok) begin
						outline_plane_q[row_index_s1[ROW_W-1:0]] <= outline_s1;
						body_plane_q[row_index_s1[ROW_W-1:0]]    <= body_s1;
					end
				end
				ACT_ARROW: begin
					for (int i = 0; i < PLANE_ROWS; i++) begin
						outline_plane_q[i] <= arrow_outline(4'(i));
						body_plane_q[i]    <= arrow_body(4'(i));
					end
					cursor_width_q  <= WIDTH_RST;
					cursor_height_q <= HEIGHT_RST;
					hot_x_q         <= '0;
					hot_y_q         <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1    <= action;
			pos_x_s1     <= pos_x;
			pos_y_s1     <= pos_y;
			pixel_s1     <= pixel_in;
			hot_x_s1     <= hot_x_in;
			hot_y_s1     <= hot_y_in;
			bytes_s1     <= source_bytes_per_row;
			rows_s1      <= source_rows;
			row_index_s1 <= row_index;
			outline_s1   <= outline_bits;
			body_s1      <= body_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && (action_s1 == ACT_PIXEL) && in_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pixel_s2 <= pixel_res;
			drawn_s2 <= drawn_res;
		end
	end

endmodule

// ===== hw/rtl/coc_checker.sv =====
// Port-level checker for the cursor overlay compositor and its bind statement.
module coc_checker
	import coc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        pixel_out,
	input logic               cursor_drawn
);

	// A result transaction that is held back must stay offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(cursor_drawn))
		else $error("stalled result changed");

	// A painted pixel is either the body color or the outline color.
	a_drawn_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cursor_drawn |-> pixel_out == PIXEL_BLACK || pixel_out == PIXEL_WHITE)
		else $error("painted pixel has a foreign color");

	// With the output register empty nothing can hold up the input side.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// The input side only stalls behind a result that the receiver holds back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

endmodule

bind cursor_overlay_compositor coc_checker u_coc_checker (.*);

// ===== tb/sv/cursor_overlay_compositor_tb.sv =====
// Self-checking testbench for the cursor overlay compositor: a directed table, then random traffic.
`timescale 1ns / 1ps

module cursor_overlay_compositor_tb
	import coc_pkg::*;
();

	typedef struct {
		logic [2:0]         act;
		logic [11:0]        x;
		logic [11:0]        y;
		logic [31:0]        pix;
		logic signed [6:0]  hx;
		logic signed [6:0]  hy;
		logic [7:0]         sbpl;
		logic [7:0]         rows;
		logic [3:0]         ridx;
		logic [15:0]        ob;
		logic [15:0]        bb;
	} item_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        drawn;
	} pixel_result_t;

	typedef struct {
		bit            is_cfg;
		item_t         it;
		bit            typed;
		bit            hit;
		pixel_result_t res;
		logic [1:0]    idx;
		logic [12:0]   val;
	} dir_row_t;

	localparam logic [15:0] ARROW_OUTLINE [16] = '{
		16'hFFFF, 16'h8001, 16'h8002, 16'h800C, 16'h8010, 16'h8010, 16'h8008, 16'h8004,
		16'h8002, 16'h8001, 16'h8002, 16'h8C04, 16'h9208, 16'h9110, 16'hA0A0, 16'hC040
	};
	localparam logic [15:0] ARROW_BODY [16] = '{
		16'h0000, 16'h7FFE, 16'h7FFC, 16'h7FF0, 16'h7FE0, 16'h7FE0, 16'h7FF0, 16'h7FF8,
		16'h7FFC, 16'h7FFE, 16'h7FFC, 16'h73F8, 16'h61F0, 16'h60E0, 16'h4040, 16'h0000
	};
	localparam int FRAME_SIZES [8] = '{1, 4096, 8191, 1024, 17, 640, 4095, 0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [12:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         action = '0;
	logic [11:0]        pos_x = '0;
	logic [11:0]        pos_y = '0;
	logic [31:0]        pixel_in = '0;
	logic signed [6:0]  hot_x_in = '0;
	logic signed [6:0]  hot_y_in = '0;
	logic [7:0]         source_bytes_per_row = '0;
	logic [7:0]         source_rows = '0;
	logic [3:0]         row_index = '0;
	logic [15:0]        outline_bits = '0;
	logic [15:0]        body_bits = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [31:0]        pixel_out;
	logic               cursor_drawn;

	cursor_overlay_compositor DUT (.*);

	always #5 clk = ~clk;

	// Predictor state.
	logic [12:0] frame_w = FRAME_WIDTH_RST;
	logic [12:0] frame_h = FRAME_HEIGHT_RST;
	logic        overlay_en = 1'b0;
	logic        host_draws = 1'b0;
	logic [11:0] cur_x = CURSOR_X_RST;
	logic [11:0] cur_y = CURSOR_Y_RST;
	int          cur_w;
	int          cur_h;
	int          hot_x;
	int          hot_y;
	logic [15:0] outline_rows [16];
	logic [15:0] body_rows [16];

	pixel_result_t expected_pixels [$];
	int errors = 0;
	int items_sent = 0;
	int pixels_checked = 0;
	int pixels_drawn = 0;
	int gap_pct = 24;
	int stall_pct = 72;
	dir_row_t directed_rows [$];

	function automatic void load_arrow_shape();
		for (int i = 0; i < 16; i++) begin
			outline_rows[i] = ARROW_OUTLINE[i];
			body_rows[i] = ARROW_BODY[i];
		end
		cur_w = 16;
		cur_h = 16;
		hot_x = 0;
		hot_y = 0;
	endfunction

	function automatic bit composite(input item_t it, output pixel_result_t r);
		int ox, oy, bx, by;
		bit hit;
		hit = 1'b0;
		r = '{pixel: it.pix, drawn: 1'b0};
		case (it.act)
			ACT_PIXEL: begin
				if (it.x < frame_w && it.y < frame_h) begin
					hit = 1'b1;
					if (!host_draws && overlay_en && cur_w != 0) begin
						ox = int'(cur_x) - hot_x;
						oy = int'(cur_y) - hot_y;
						bx = int'(it.x) - ox;
						by = int'(it.y) - oy;
						if (bx >= 0 && bx < cur_w && bx < 16 && by >= 0 && by < cur_h && by < 16) begin
							if (body_rows[by][15 - bx])
								r = '{pixel: PIXEL_BLACK, drawn: 1'b1};
							else if (outline_rows[by][15 - bx])
								r = '{pixel: PIXEL_WHITE, drawn: 1'b1};
						end
					end
				end
			end
			ACT_MOVE: begin
				if (!host_draws) begin
					cur_x = it.x;
					cur_y = it.y;
				end
			end
			ACT_BEGIN: begin
				cur_w = (it.sbpl > 8'd2) ? 16 : int'(it.sbpl) * 8;
				cur_h = (it.rows > 8'd16) ? 16 : int'(it.rows);
				for (int i = 0; i < 16; i++) begin
					outline_rows[i] = '0;
					body_rows[i] = '0;
				end
				hot_x = it.hx;
				hot_y = it.hy;
			end
			ACT_ROW: begin
				if (int'(it.ridx) < cur_h) begin
					outline_rows[it.ridx] = it.ob;
					body_rows[it.ridx] = it.bb;
				end
			end
			ACT_ARROW: load_arrow_shape();
			default: ;
		endcase
		return hit;
	endfunction

	function automatic item_t plain_item(input logic [2:0] act);
		item_t it;
		it = '{default: 0};
		it.act = act;
		return it;
	endfunction

	function automatic item_t pixel_item(input logic [11:0] x, input logic [11:0] y,
			input logic [31:0] p);
		item_t it;
		it = plain_item(ACT_PIXEL);
		it.x = x;
		it.y = y;
		it.pix = p;
		return it;
	endfunction

	function automatic item_t move_item(input logic [11:0] x, input logic [11:0] y);
		item_t it;
		it = plain_item(ACT_MOVE);
		it.x = x;
		it.y = y;
		return it;
	endfunction

	function automatic item_t shape_item(input logic signed [6:0] hx, input logic signed [6:0] hy,
			input logic [7:0] sbpl, input logic [7:0] rows);
		item_t it;
		it = plain_item(ACT_BEGIN);
		it.hx = hx;
		it.hy = hy;
		it.sbpl = sbpl;
		it.rows = rows;
		return it;
	endfunction

	function automatic item_t row_item(input logic [3:0] r, input logic [15:0] o,
			input logic [15:0] b);
		item_t it;
		it = plain_item(ACT_ROW);
		it.ridx = r;
		it.ob = o;
		it.bb = b;
		return it;
	endfunction

	function automatic dir_row_t checked_row(input item_t it);
		dir_row_t d;
		d = '{default: 0};
		d.it = it;
		return d;
	endfunction

	function automatic dir_row_t typed_row(input item_t it, input bit hit,
			input logic [31:0] p, input bit drawn);
		dir_row_t d;
		d = checked_row(it);
		d.typed = 1'b1;
		d.hit = hit;
		d.res = '{pixel: p, drawn: drawn};
		return d;
	endfunction

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [12:0] val);
		dir_row_t d;
		d = '{default: 0};
		d.is_cfg = 1'b1;
		d.idx = idx;
		d.val = val;
		return d;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int sel, lim_x, lim_y;
		it.act = ACT_PIXEL;
		it.x = 12'($urandom);
		it.y = 12'($urandom);
		it.pix = $urandom;
		it.hx = 7'($urandom);
		it.hy = 7'($urandom);
		it.sbpl = 8'($urandom);
		it.rows = 8'($urandom);
		it.ridx = 4'($urandom);
		it.ob = 16'($urandom);
		it.bb = 16'($urandom);
		lim_x = (frame_w > 13'd4096) ? 4095 : int'(frame_w) - 1;
		lim_y = (frame_h > 13'd4096) ? 4095 : int'(frame_h) - 1;
		if (lim_x < 0)
			lim_x = 0;
		if (lim_y < 0)
			lim_y = 0;
		sel = $urandom_range(99);
		if (sel < 55) begin
			case ($urandom_range(3))
				0, 1: begin
					it.x = 12'(int'(cur_x) - hot_x + int'($urandom_range(0, 19)) - 2);
					it.y = 12'(int'(cur_y) - hot_y + int'($urandom_range(0, 19)) - 2);
				end
				2: begin
					it.x = 12'($urandom_range(0, lim_x));
					it.y = 12'($urandom_range(0, lim_y));
				end
				default: ;
			endcase
		end else if (sel < 63) begin
			it.act = ACT_MOVE;
			case ($urandom_range(2))
				0: begin
					it.x = 12'($urandom_range(0, lim_x));
					it.y = 12'($urandom_range(0, lim_y));
				end
				1: begin
					it.x = $urandom_range(1) ? 12'($urandom_range(0, 20))
						: 12'(4095 - $urandom_range(0, 20));
					it.y = $urandom_range(1) ? 12'($urandom_range(0, 20))
						: 12'(4095 - $urandom_range(0, 20));
				end
				default: ;
			endcase
		end else if (sel < 68) begin
			it.act = ACT_BEGIN;
			if ($urandom_range(4) != 0)
				it.sbpl = 8'($urandom_range(0, 3));
			if ($urandom_range(4) != 0)
				it.rows = 8'($urandom_range(0, 17));
		end else if (sel < 88) begin
			it.act = ACT_ROW;
		end else if (sel < 92) begin
			it.act = ACT_ARROW;
		end else if (sel < 95) begin
			it.act = 3'($urandom_range(5, 7));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input bit typed, input bit t_hit,
			input pixel_result_t t_res);
		pixel_result_t res;
		bit hit;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		pos_x <= it.x;
		pos_y <= it.y;
		pixel_in <= it.pix;
		hot_x_in <= it.hx;
		hot_y_in <= it.hy;
		source_bytes_per_row <= it.sbpl;
		source_rows <= it.rows;
		row_index <= it.ridx;
		outline_bits <= it.ob;
		body_bits <= it.bb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hit = composite(it, res);
		if (typed) begin
			hit = t_hit;
			res = t_res;
		end
		if (hit)
			expected_pixels.push_back(res);
		items_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:   frame_w = val;
			REG_FRAME_HEIGHT:  frame_h = val;
			REG_CURSOR_ENABLE: overlay_en = val[0];
			default:           host_draws = val[0];
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		pixel_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected transaction: pixel_out %h, cursor_drawn %b",
					pixel_out, cursor_drawn);
				errors++;
			end else begin
				exp_res = expected_pixels.pop_front();
				pixels_checked++;
				if (cursor_drawn === 1'b1)
					pixels_drawn++;
				if (pixel_out !== exp_res.pixel) begin
					$error("pixel_out: expected %h, got %h", exp_res.pixel, pixel_out);
					errors++;
				end
				if (cursor_drawn !== exp_res.drawn) begin
					$error("cursor_drawn: expected %b, got %b", exp_res.drawn, cursor_drawn);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int b, n;
		item_t it;
		logic [12:0] fw_val, fh_val;
		load_arrow_shape();

		// After reset the overlay is off and the frame is 1024 by 768.
		directed_rows.push_back(typed_row(pixel_item(0, 0, 32'hDEADBEEF), 1, 32'hDEADBEEF, 0));
		directed_rows.push_back(typed_row(pixel_item(1023, 767, 32'hFFFFFFFF), 1,
			32'hFFFFFFFF, 0));
		directed_rows.push_back(typed_row(pixel_item(1024, 0, 32'h1), 0, 0, 0));
		directed_rows.push_back(typed_row(pixel_item(0, 768, 32'h2), 0, 0, 0));
		directed_rows.push_back(cfg_row(REG_CURSOR_ENABLE, 13'd1));
		directed_rows.push_back(typed_row(pixel_item(512, 384, 32'h12345678), 1, PIXEL_WHITE, 1));
		directed_rows.push_back(typed_row(pixel_item(513, 385, 32'h87654321), 1, PIXEL_BLACK, 1));
		directed_rows.push_back(typed_row(pixel_item(527, 399, 32'hCAFEF00D), 1,
			32'hCAFEF00D, 0));
		directed_rows.push_back(typed_row(pixel_item(528, 384, 32'hFFFFFFFF), 1,
			32'hFFFFFFFF, 0));
		directed_rows.push_back(typed_row(pixel_item(511, 384, 32'h01010101), 1,
			32'h01010101, 0));
		directed_rows.push_back(typed_row(plain_item(3'd5), 0, 0, 0));
		directed_rows.push_back(typed_row(plain_item(3'd7), 0, 0, 0));
		directed_rows.push_back(checked_row(move_item(0, 0)));
		directed_rows.push_back(typed_row(pixel_item(0, 0, 32'h11111111), 1, PIXEL_WHITE, 1));
		// An eight-wide shape whose hot spot pulls the box right and up; low byte unseen.
		directed_rows.push_back(checked_row(shape_item(-7'sd4, 7'sd2, 8'd1, 8'd255)));
		directed_rows.push_back(checked_row(row_item(4'd3, 16'hF0FF, 16'hCCFF)));
		directed_rows.push_back(checked_row(row_item(4'd15, 16'hFFFF, 16'h0000)));
		directed_rows.push_back(checked_row(pixel_item(4, 1, 32'hA5A5A5A5)));
		directed_rows.push_back(checked_row(pixel_item(6, 1, 32'h5A5A5A5A)));
		directed_rows.push_back(checked_row(pixel_item(12, 1, 32'h3C3C3C3C)));
		directed_rows.push_back(checked_row(pixel_item(4, 15, 32'h0F0F0F0F)));
		directed_rows.push_back(checked_row(shape_item(-7'sd64, 7'sd63, 8'd0, 8'd16)));
		directed_rows.push_back(checked_row(pixel_item(64, 0, 32'h00C0FFEE)));
		directed_rows.push_back(checked_row(shape_item(7'sd63, -7'sd64, 8'd255, 8'd0)));
		directed_rows.push_back(checked_row(row_item(4'd0, 16'hFFFF, 16'hFFFF)));
		directed_rows.push_back(checked_row(pixel_item(0, 64, 32'h00BADBAD)));
		directed_rows.push_back(checked_row(shape_item(7'sd0, 7'sd0, 8'd2, 8'd3)));
		directed_rows.push_back(checked_row(row_item(4'd3, 16'hFFFF, 16'hFFFF)));
		directed_rows.push_back(checked_row(row_item(4'd2, 16'h0001, 16'h8000)));
		directed_rows.push_back(checked_row(pixel_item(0, 2, 32'h13579BDF)));
		directed_rows.push_back(checked_row(pixel_item(15, 2, 32'h2468ACE0)));
		directed_rows.push_back(checked_row(pixel_item(0, 3, 32'h77777777)));
		directed_rows.push_back(checked_row(plain_item(ACT_ARROW)));
		directed_rows.push_back(cfg_row(REG_HOST_CURSOR, 13'd1));
		directed_rows.push_back(checked_row(move_item(100, 100)));
		directed_rows.push_back(typed_row(pixel_item(0, 0, 32'h44444444), 1, 32'h44444444, 0));
		directed_rows.push_back(cfg_row(REG_HOST_CURSOR, 13'd0));
		directed_rows.push_back(typed_row(pixel_item(0, 0, 32'h55555555), 1, PIXEL_WHITE, 1));
		directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 13'd0));
		directed_rows.push_back(typed_row(pixel_item(0, 0, 32'h66666666), 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				drain_pipeline();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].hit,
					directed_rows[i].res);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
			stall_pct = (phase == 0) ? 72 : (phase == 1) ? 24 : 0;
			for (int blk = 0; blk < 5; blk++) begin
				b = phase * 5 + blk;
				fw_val = (b % 8 == 7) ? 13'($urandom_range(1, 8191)) : 13'(FRAME_SIZES[b % 8]);
				fh_val = ((b * 3 + 1) % 8 == 7) ? 13'($urandom_range(1, 8191))
					: 13'(FRAME_SIZES[(b * 3 + 1) % 8]);
				drain_pipeline();
				write_reg(REG_FRAME_WIDTH, fw_val);
				write_reg(REG_FRAME_HEIGHT, fh_val);
				write_reg(REG_CURSOR_ENABLE, (13'($urandom) & 13'h1FFE) | 13'(b % 5 != 4));
				write_reg(REG_HOST_CURSOR, (13'($urandom) & 13'h1FFE) | 13'(b % 7 == 3));
				n = 0;
				while (n < 130) begin
					it = random_item();
					send_item(it, 0, 0, '0);
					if (it.act <= ACT_ARROW)
						n++;
				end
			end
		end

		drain_pipeline();
		repeat (8) @(posedge clk);
		$display("Sent %0d transactions; checked %0d output pixels, %0d of them cursor pixels.",
			items_sent, pixels_checked, pixels_drawn);
		$display("Frame sizes from 0 to 8191, shape loads and overlay-off cases, three stall mixes.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
